// ----- rtl/core/spadd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spadd_pkg: shared types and codes for the sparse polynomial adder
// Word formats for the request and response channels, the stored term
// format and the command codes.
// ----------------------------------------------------------------------------
package spadd_pkg;

   // default term capacity of each list
   localparam int unsigned DEPTH_DEF = 32;

   // field widths
   localparam int unsigned COEF_W     = 32;
   localparam int unsigned SUM_COEF_W = 33;
   localparam int unsigned EXP_W      = 16;
   localparam int unsigned CMD_W      = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

   // request word
   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [COEF_W-1:0] coefficient;
      logic [EXP_W-1:0]         exponent;
   } req_word_type;

   // response word
   typedef struct packed {
      logic signed [SUM_COEF_W-1:0] sum_coefficient;
      logic [EXP_W-1:0]             sum_exponent;
      logic                         last_term;
      logic                         empty_result;
      logic                         overflow;
   } rsp_word_type;

   // one stored term
   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [EXP_W-1:0]         exponent;
   } term_type;

endpackage : spadd_pkg
`default_nettype wire

// ----- rtl/core/sparse_polynomial_add_merge_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_polynomial_add_merge_top: sparse polynomial adder
// Loads terms into two term memories, then merges both lists by descending
// exponent, adding coefficients of equal exponents.
//
//   Channel   Dir   Handshake              Word
//   req_*     in    req_valid/req_ready    spadd_pkg::req_word_type
//   rsp_*     out   rsp_valid/rsp_ready    spadd_pkg::rsp_word_type
//
// Loads stream at one word per cycle while no merge is walking the lists.
// Once a merge is accepted, it emits one word per cycle unless the response stalls,
// count_a + count_b words at most (one word when both lists are empty),
// paced by the single read port of each term memory.
// req_ready is low while a merge is walking the lists; a stalled response
// holds the read indices. Synchronous active-high reset clears the counts,
// the overflow flag and the response valid; memory contents are not reset.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_merge_top #(
   parameter int unsigned DEPTH = spadd_pkg::DEPTH_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   // request channel
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire spadd_pkg::req_word_type req_word,
   // response channel
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output spadd_pkg::rsp_word_type rsp_word
);
   import spadd_pkg::*;

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   // state and registered outputs
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0] cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] idx_a_ff, idx_a_in;
   logic [CNT_W-1:0] idx_b_ff, idx_b_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   // term memories and their registered read data
   term_type mem_a [DEPTH];
   term_type mem_b [DEPTH];
   term_type rd_a_ff;
   term_type rd_b_ff;

   logic             req_fire;
   logic             wr_a;
   logic             wr_b;
   term_type         wr_term;
   logic             live_a;
   logic             live_b;
   logic             take_a;
   logic             take_b;
   logic             emit;
   logic             last;
   logic [CNT_W-1:0] next_a;
   logic [CNT_W-1:0] next_b;
   logic signed [SUM_COEF_W-1:0] ext_a;
   logic signed [SUM_COEF_W-1:0] ext_b;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // load decode
   assign wr_term.coefficient = req_word.coefficient;
   assign wr_term.exponent    = req_word.exponent;
   assign wr_a = req_fire && (req_word.command == CMD_LOAD_A) && (cnt_a_ff < DEPTH_CNT);
   assign wr_b = req_fire && (req_word.command == CMD_LOAD_B) && (cnt_b_ff < DEPTH_CNT);

   // head selection
   assign live_a = (idx_a_ff < cnt_a_ff);
   assign live_b = (idx_b_ff < cnt_b_ff);
   assign ext_a  = {rd_a_ff.coefficient[COEF_W-1], rd_a_ff.coefficient};
   assign ext_b  = {rd_b_ff.coefficient[COEF_W-1], rd_b_ff.coefficient};

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      if (live_a && live_b) begin
         take_a = (rd_a_ff.exponent >= rd_b_ff.exponent);
         take_b = (rd_b_ff.exponent >= rd_a_ff.exponent);
      end else begin
         take_a = live_a;
         take_b = live_b;
      end
   end

   assign emit   = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_ready);
   assign next_a = take_a ? idx_a_ff + CNT_ONE : idx_a_ff;
   assign next_b = take_b ? idx_b_ff + CNT_ONE : idx_b_ff;
   assign last   = (next_a == cnt_a_ff) && (next_b == cnt_b_ff);

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_word.command)
                  CMD_LOAD_A: begin
                     if (wr_a) cnt_a_in = cnt_a_ff + CNT_ONE;
                     else      dropped_in = 1'b1;
                  end
                  CMD_LOAD_B: begin
                     if (wr_b) cnt_b_in = cnt_b_ff + CNT_ONE;
                     else      dropped_in = 1'b1;
                  end
                  CMD_MERGE: begin
                     state_in = ST_MERGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (emit) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.overflow      = dropped_ff;
               rsp_word_in.last_term     = last;
               rsp_word_in.empty_result  = !live_a && !live_b;
               if (take_a && take_b) begin
                  rsp_word_in.sum_coefficient = ext_a + ext_b;
                  rsp_word_in.sum_exponent    = rd_a_ff.exponent;
               end else if (take_a) begin
                  rsp_word_in.sum_coefficient = ext_a;
                  rsp_word_in.sum_exponent    = rd_a_ff.exponent;
               end else if (take_b) begin
                  rsp_word_in.sum_coefficient = ext_b;
                  rsp_word_in.sum_exponent    = rd_b_ff.exponent;
               end else begin
                  rsp_word_in.sum_coefficient = '0;
                  rsp_word_in.sum_exponent    = '0;
               end
               idx_a_in = next_a;
               idx_b_in = next_b;
               if (last) begin
                  state_in   = ST_IDLE;
                  cnt_a_in   = '0;
                  cnt_b_in   = '0;
                  idx_a_in   = '0;
                  idx_b_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   // term memories: one write port, one read port each; the read address is
   // the next index so the head term lines up with the index register
   always_ff @(posedge clock) begin
      if (wr_a) mem_a[cnt_a_ff[ADDR_W-1:0]] <= wr_term;
      if (wr_b) mem_b[cnt_b_ff[ADDR_W-1:0]] <= wr_term;
      rd_a_ff <= mem_a[idx_a_in[ADDR_W-1:0]];
      rd_b_ff <= mem_b[idx_b_in[ADDR_W-1:0]];
   end

`ifndef NO_ASSERTIONS
   // read indices never pass the fill counts
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (idx_a_ff <= cnt_a_ff) && (idx_b_ff <= cnt_b_ff))
      else $error("read index past fill count");

   // fill counts stay within capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= DEPTH_CNT) && (cnt_b_ff <= DEPTH_CNT))
      else $error("fill count above capacity");

   // idle means indices are rewound
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (idx_a_ff == '0) && (idx_b_ff == '0))
      else $error("indices not rewound in idle");

   // the final word of a merge clears both lists and the overflow flag
   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> (cnt_a_ff == '0) && (cnt_b_ff == '0) && !dropped_ff
                         && rsp_valid_ff && rsp_word_ff.last_term)
      else $error("merge end did not clear state");

   // an empty result is always the only and last word
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.empty_result) |-> rsp_word_ff.last_term)
      else $error("empty result not marked last");
`endif
endmodule : sparse_polynomial_add_merge_top
`default_nettype wire

// ----- tb/sv/tb_sparse_polynomial_add_merge_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_add_merge_top: self-checking bench for the sparse adder
// Streams term loads and merge commands with random gaps and a throttled
// response side. Each merge is predicted from a local copy of both term
// lists, and every response word is checked in order against it.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_add_merge_top;
   import spadd_pkg::*;

   localparam int unsigned LIST_DEPTH   = DEPTH_DEF;
   localparam int unsigned RANDOM_ITEMS = 280;
   localparam int unsigned TAIL_CYCLES  = 20;
   // the one command code the block ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      req_word_type word;
      int           gap;
      bit           wait_idle;
   } pending_word_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   // stimulus and expected response words
   pending_word_type pending_q[$];
   pending_word_type head;
   rsp_word_type     expected_q[$];
   int               expected_count = 0;

   // local copy of the term lists
   term_type model_a[LIST_DEPTH];
   term_type model_b[LIST_DEPTH];
   int       model_count_a = 0;
   int       model_count_b = 0;
   bit       model_dropped = 1'b0;

   // pacing state
   int gap_left     = 0;
   bit gap_loaded   = 1'b0;
   int calm_left    = 0;
   int stall_left   = 0;
   int stall_pct    = 25;
   bit idle_request = 1'b0;

   // bookkeeping
   int error_count   = 0;
   int random_items  = 0;
   int load_count    = 0;
   int merge_count   = 0;
   int empty_merges  = 0;
   int dropped_merges = 0;
   int ignored_count = 0;
   int checked_count = 0;

   always #6 clock = ~clock;

   sparse_polynomial_add_merge_top #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // idle length: mostly short, a few long
   function automatic int stall_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   // gap before a request word, with stretches of back-to-back words
   function automatic int next_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm_left = $urandom_range(10, 30);
         return 0;
      end
      if (r < 55) return 0;
      return stall_length();
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'h7FFF_FFFF;
      if (r < 20) return 32'h8000_0000;
      if (r < 25) return '0;
      return $urandom;
   endfunction

   task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [COEF_W-1:0] coef,
                            input logic [EXP_W-1:0] expo);
      pending_word_type p;
      p.word.command     = cmd;
      p.word.coefficient = coef;
      p.word.exponent    = expo;
      p.gap              = next_gap();
      p.wait_idle        = idle_request;
      // the pause check needs a nonzero gap after the previous merge
      if (p.wait_idle && p.gap < 1) p.gap = 1;
      idle_request = 1'b0;
      pending_q.push_back(p);
      if (cmd != CMD_UNUSED) random_items++;
   endtask

   // n loads into one list with strictly descending exponents
   task automatic load_run(input logic [CMD_W-1:0] cmd, input int n);
      int cur, rest, step_max;
      cur = $urandom_range(65535, n - 1);
      for (int k = 0; k < n; k++) begin
         push_item(cmd, rand_coef(), EXP_W'(cur));
         rest = n - 1 - k;
         if (rest > 0) begin
            step_max = cur - (rest - 1);
            if (step_max > 3000) step_max = 3000;
            cur -= $urandom_range(1, step_max);
         end
      end
   endtask

   // two sorted polynomials sharing some exponents, loads interleaved, then merge
   task automatic gen_poly_pair(input int total);
      term_type         list_a[$];
      term_type         list_b[$];
      int               cur, rest, step_max, pick, ia, ib;
      logic [COEF_W-1:0] c;
      cur = $urandom_range(65535, total - 1);
      for (int t = 0; t < total; t++) begin
         if (list_a.size() >= LIST_DEPTH && list_b.size() >= LIST_DEPTH) break;
         pick = $urandom_range(0, 2);
         if (list_a.size() >= LIST_DEPTH) pick = 1;
         if (list_b.size() >= LIST_DEPTH) pick = 0;
         c = rand_coef();
         if (pick != 1) list_a.push_back('{coefficient: c, exponent: EXP_W'(cur)});
         if (pick == 2 && $urandom_range(0, 9) < 3) c = -c;
         else if (pick == 2) c = rand_coef();
         if (pick != 0) list_b.push_back('{coefficient: c, exponent: EXP_W'(cur)});
         rest = total - 1 - t;
         if (rest > 0) begin
            step_max = cur - (rest - 1);
            if (step_max > 4000) step_max = 4000;
            cur -= $urandom_range(1, step_max);
         end
      end
      ia = 0;
      ib = 0;
      while (ia < list_a.size() || ib < list_b.size()) begin
         if (ib >= list_b.size() || (ia < list_a.size() && $urandom_range(0, 1))) begin
            push_item(CMD_LOAD_A, list_a[ia].coefficient, list_a[ia].exponent);
            ia++;
         end else begin
            push_item(CMD_LOAD_B, list_b[ib].coefficient, list_b[ib].exponent);
            ib++;
         end
      end
      push_item(CMD_MERGE, rand_coef(), EXP_W'($urandom_range(0, 65535)));
   endtask

   // predictor: update the local lists and queue the words a merge produces
   task automatic predict_word(input req_word_type w);
      rsp_word_type                 r;
      int                           i, j;
      logic signed [SUM_COEF_W-1:0] ca, cb;
      case (w.command)
         CMD_LOAD_A: begin
            load_count++;
            if (model_count_a < LIST_DEPTH) begin
               model_a[model_count_a] = '{coefficient: w.coefficient, exponent: w.exponent};
               model_count_a++;
            end else begin
               model_dropped = 1'b1;
            end
         end
         CMD_LOAD_B: begin
            load_count++;
            if (model_count_b < LIST_DEPTH) begin
               model_b[model_count_b] = '{coefficient: w.coefficient, exponent: w.exponent};
               model_count_b++;
            end else begin
               model_dropped = 1'b1;
            end
         end
         CMD_MERGE: begin
            merge_count++;
            if (model_dropped) dropped_merges++;
            if (model_count_a == 0 && model_count_b == 0) begin
               // both lists empty: a single marker word
               empty_merges++;
               r              = '0;
               r.last_term    = 1'b1;
               r.empty_result = 1'b1;
               r.overflow     = model_dropped;
               expected_q.push_back(r);
            end else begin
               i = 0;
               j = 0;
               while (i < model_count_a || j < model_count_b) begin
                  r          = '0;
                  r.overflow = model_dropped;
                  ca = {model_a[i % LIST_DEPTH].coefficient[COEF_W-1],
                        model_a[i % LIST_DEPTH].coefficient};
                  cb = {model_b[j % LIST_DEPTH].coefficient[COEF_W-1],
                        model_b[j % LIST_DEPTH].coefficient};
                  if (j >= model_count_b ||
                      (i < model_count_a && model_a[i].exponent > model_b[j].exponent)) begin
                     r.sum_coefficient = ca;
                     r.sum_exponent    = model_a[i].exponent;
                     i++;
                  end else if (i >= model_count_a ||
                               model_a[i].exponent < model_b[j].exponent) begin
                     r.sum_coefficient = cb;
                     r.sum_exponent    = model_b[j].exponent;
                     j++;
                  end else begin
                     // equal exponents: one term, widened sum
                     r.sum_coefficient = ca + cb;
                     r.sum_exponent    = model_a[i].exponent;
                     i++;
                     j++;
                  end
                  r.last_term = (i >= model_count_a && j >= model_count_b);
                  expected_q.push_back(r);
               end
            end
            model_count_a = 0;
            model_count_b = 0;
            model_dropped = 1'b0;
         end
         default: ignored_count++;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("[%0t] %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_word(input rsp_word_type got);
      rsp_word_type want;
      if (expected_q.size() == 0) begin
         $display("[%0t] response word with none expected: expected none, actual %p",
                  $time, got);
         error_count++;
      end else begin
         want = expected_q.pop_front();
         checked_count++;
         compare_field("sum_coefficient", want.sum_coefficient, got.sum_coefficient);
         compare_field("sum_exponent", want.sum_exponent, got.sum_exponent);
         compare_field("last_term", want.last_term, got.last_term);
         compare_field("empty_result", want.empty_result, got.empty_result);
         compare_field("overflow", want.overflow, got.overflow);
      end
   endtask

   // request driver: holds a word until accepted, then waits out the next gap and, if asked, the drain
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_loaded = 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (pending_q.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            if (!gap_loaded) begin
               gap_left   = pending_q[0].gap;
               gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q[0].wait_idle && expected_count != 0) begin
               req_valid <= 1'b0;
            end else begin
               head       = pending_q.pop_front();
               gap_loaded = 1'b0;
               req_word  <= head.word;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor: check responses, predict accepted requests, throttle rsp_ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_word(rsp_word);
         if (req_valid && req_ready) predict_word(req_word);
         // switch between stretches with and without stalls
         if ($urandom_range(0, 99) == 0) stall_pct = (stall_pct == 0) ? 25 : 0;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = stall_length() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
      expected_count <= expected_q.size();
   end

   // stimulus, end of run and verdict
   initial begin
      int                kind, n;
      logic [CMD_W-1:0]  cmd_pick;

      // both lists empty
      push_item(CMD_MERGE, '0, '0);
      // extreme coefficients at both exponent ends, after a full drain
      idle_request = 1'b1;
      push_item(CMD_LOAD_A, 32'h7FFF_FFFF, 16'hFFFF);
      push_item(CMD_LOAD_B, 32'h7FFF_FFFF, 16'hFFFF);
      push_item(CMD_LOAD_A, 32'h8000_0000, 16'h0000);
      push_item(CMD_LOAD_B, 32'h8000_0000, 16'h0000);
      push_item(CMD_MERGE, '0, '0);
      // sum to zero, then the tail of list B
      push_item(CMD_LOAD_A, 32'd5, 16'd1000);
      push_item(CMD_LOAD_B, -32'sd5, 16'd1000);
      push_item(CMD_LOAD_A, 32'd7, 16'd700);
      push_item(CMD_LOAD_B, 32'd3, 16'd300);
      push_item(CMD_LOAD_B, -32'sd1, 16'd0);
      push_item(CMD_MERGE, '0, '0);
      // only list B, then only list A
      push_item(CMD_LOAD_B, 32'd11, 16'd100);
      push_item(CMD_LOAD_B, 32'd22, 16'd50);
      push_item(CMD_MERGE, '0, '0);
      push_item(CMD_LOAD_A, 32'd42, 16'd12345);
      push_item(CMD_MERGE, '0, '0);
      // ignored command leaves state alone
      push_item(CMD_UNUSED, $urandom, EXP_W'($urandom_range(0, 65535)));
      push_item(CMD_MERGE, '0, '0);
      // unsorted list A merged as stored
      push_item(CMD_LOAD_A, 32'd1, 16'd1);
      push_item(CMD_LOAD_A, 32'd9, 16'd9);
      push_item(CMD_LOAD_B, 32'd5, 16'd5);
      push_item(CMD_MERGE, '0, '0);

      // random part
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) idle_request = 1'b1;
         if (kind < 72) begin
            n = $urandom_range(0, 99);
            if (n < 75) gen_poly_pair($urandom_range(1, 8));
            else if (n < 95) gen_poly_pair($urandom_range(9, 24));
            else gen_poly_pair(2 * LIST_DEPTH);
         end else if (kind < 78) begin
            // overfill one or both lists
            n = $urandom_range(0, 2);
            if (n != 1) load_run(CMD_LOAD_A, LIST_DEPTH + $urandom_range(1, 3));
            if (n != 0) load_run(CMD_LOAD_B, LIST_DEPTH + $urandom_range(1, 3));
            else load_run(CMD_LOAD_B, $urandom_range(1, 4));
            push_item(CMD_MERGE, rand_coef(), EXP_W'($urandom_range(0, 65535)));
         end else if (kind < 90) begin
            // noise: any command, any fields
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               cmd_pick = CMD_W'($urandom_range(0, 3));
               push_item(cmd_pick, $urandom, EXP_W'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 9) < 7) push_item(CMD_MERGE, $urandom, '1);
         end else begin
            if ($urandom_range(0, 1)) push_item(CMD_UNUSED, $urandom, '1);
            push_item(CMD_MERGE, $urandom, EXP_W'($urandom_range(0, 65535)));
         end
      end
      push_item(CMD_MERGE, '0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_q.size() != 0) begin
         $display("[%0t] %0d response words never arrived", $time, expected_q.size());
         error_count++;
      end
      $display("covered %0d loads and %0d merges (%0d with empty lists, %0d with dropped loads)",
               load_count, merge_count, empty_merges, dropped_merges);
      $display("%0d ignored words, %0d response words checked, %0d errors",
               ignored_count, checked_count, error_count);
      if (error_count == 0) begin
         $display("sparse_polynomial_add_merge_top verification clean");
      end else begin
         $display("sparse_polynomial_add_merge_top verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[%0t] timeout: %0d words unsent, %0d responses outstanding",
               $time, pending_q.size(), expected_q.size());
      $display("sparse_polynomial_add_merge_top verification failed");
      $finish;
   end

endmodule

// ----- sparse_polynomial_add_merge_top.f -----
rtl/core/spadd_pkg.sv
rtl/core/sparse_polynomial_add_merge_top.sv
tb/sv/tb_sparse_polynomial_add_merge_top.sv
